@@ src/assert_macros.svh @@
// Assertion helpers, clocked on the block clock and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain expression checked at every edge
`define QPPE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Expression that must never be true
`define QPPE_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

@@ src/qppe_pkg.sv @@
package qppe_pkg;

   localparam int MAX_SIDE   = 32;
   localparam int FRAC_BITS  = 16;
   localparam int SIDE_BITS  = $clog2(MAX_SIDE);
   localparam int ADDR_BITS  = 2 * SIDE_BITS;
   localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
   localparam int NUM_CH     = 5;
   localparam int NUM_TAPS   = 5;
   localparam int WORD_BITS  = 32;
   localparam int QUERY_BITS = 21;
   localparam int CFG_BITS   = 6;
   localparam int POS_BITS   = 5;
   localparam int CEN_BITS   = QUERY_BITS - FRAC_BITS + 1;
   localparam int IDX_BITS   = CEN_BITS + SIDE_BITS + 3;
   localparam int TAP_BITS   = 3;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef word_type [NUM_CH-1:0]       point_type;
   typedef point_type [NUM_TAPS-1:0]    taps_type;
   typedef logic [FRAC_BITS-1:0]        frac_type;
   typedef logic [SIDE_BITS:0]          side_type;
   typedef logic [CEN_BITS-1:0]         cen_type;

   typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CORNER, ST_WAIT} state_type;
   typedef enum logic {CSR_GRID_COLS = 1'b0, CSR_GRID_ROWS = 1'b1} csr_index_type;

   typedef struct packed {
      logic                valid;
      logic                last_pass;
      logic [TAP_BITS-1:0] row;
   } red_tag_type;

   // a + floor((b - a) * t / 2^FRAC_BITS); result lies between a and b
   function automatic word_type lerp(word_type a, word_type b, frac_type t);
      logic signed [WORD_BITS:0]                   diff;
      logic signed [FRAC_BITS:0]                   ts;
      logic signed [WORD_BITS+FRAC_BITS+1:0]       prod;
      logic signed [WORD_BITS+FRAC_BITS+1:0]       shifted;
      diff    = {b[WORD_BITS-1], b} - {a[WORD_BITS-1], a};
      ts      = $signed({1'b0, t});
      prod    = diff * ts;
      shifted = prod >>> FRAC_BITS;
      return a + word_type'(shifted[WORD_BITS-1:0]);
   endfunction

   // zero acts as one, above the store side acts as the side
   function automatic side_type eff_side(logic [CFG_BITS-1:0] r);
      if (r == '0) begin
         return side_type'(1);
      end else if (32'(r) > MAX_SIDE) begin
         return side_type'(MAX_SIDE);
      end
      return side_type'(r);
   endfunction

   function automatic logic [SIDE_BITS-1:0] clamp_idx(logic signed [IDX_BITS-1:0] v,
                                                      side_type n);
      logic signed [IDX_BITS-1:0] ns;
      ns = $signed(IDX_BITS'(n));
      if (v < 0) begin
         return '0;
      end else if (v >= ns) begin
         return SIDE_BITS'(n - side_type'(1));
      end
      return v[SIDE_BITS-1:0];
   endfunction

endpackage

@@ src/qppe_point_ram.sv @@
module qppe_point_ram #(
   parameter int WIDTH = 160,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/qppe_reduce.sv @@
// Five-tap quadratic reduction, all channels in parallel, three stages
module qppe_reduce (
   input  logic                 clock,
   input  logic                 reset,
   input  qppe_pkg::red_tag_type tag_in,
   input  qppe_pkg::taps_type   taps,
   input  qppe_pkg::frac_type   t_in,
   output qppe_pkg::red_tag_type tag_out,
   output qppe_pkg::point_type  result
);

   qppe_pkg::red_tag_type tag1_ff, tag2_ff, tag3_ff;
   qppe_pkg::point_type   m0_ff, m1_ff, p2_ff, a_ff, b_ff, res_ff;
   qppe_pkg::point_type   m0_in, m1_in;
   qppe_pkg::frac_type    t1_ff, t2_ff;

   always_comb begin
      for (int c = 0; c < qppe_pkg::NUM_CH; c++) begin
         logic signed [qppe_pkg::WORD_BITS+2:0] s0, s1;
         s0 = (qppe_pkg::WORD_BITS+3)'(taps[0][c]) + ((qppe_pkg::WORD_BITS+3)'(taps[1][c]) <<< 1)
              + (qppe_pkg::WORD_BITS+3)'(taps[2][c]);
         s1 = (qppe_pkg::WORD_BITS+3)'(taps[2][c]) + ((qppe_pkg::WORD_BITS+3)'(taps[3][c]) <<< 1)
              + (qppe_pkg::WORD_BITS+3)'(taps[4][c]);
         s0 = s0 >>> 2;
         s1 = s1 >>> 2;
         m0_in[c] = s0[qppe_pkg::WORD_BITS-1:0];
         m1_in[c] = s1[qppe_pkg::WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
      m0_ff <= m0_in;
      m1_ff <= m1_in;
      p2_ff <= taps[2];
      t1_ff <= t_in;
      t2_ff <= t1_ff;
      for (int c = 0; c < qppe_pkg::NUM_CH; c++) begin
         a_ff[c]   <= qppe_pkg::lerp(m0_ff[c], p2_ff[c], t1_ff);
         b_ff[c]   <= qppe_pkg::lerp(p2_ff[c], m1_ff[c], t1_ff);
         res_ff[c] <= qppe_pkg::lerp(a_ff[c], b_ff[c], t2_ff);
      end
   end

   assign tag_out = tag3_ff;
   assign result  = res_ff;

endmodule

@@ src/quadratic_patch_point_evaluator.sv @@
// Quadratic patch point evaluator. A write request (mode 0) stores one control
// point straight into the memory and gives no response. An evaluate request
// (mode 1) gives exactly one response strobe, rsp_valid, lasting one cycle.
// For a full evaluation the strobe follows, in order: the 25 reads from the
// one-port point memory, the memory's read register, a row pass for each row
// and a column pass through the three-stage reduction, and the output
// register. When the centre point is returned unchanged (rsp_corner_copy high)
// the strobe follows one read, the memory's read register and the output
// register. busy is high from an evaluate request until its strobe, so the
// next request can be accepted at the edge that takes the strobe. The response
// cannot be held off, so take it in the cycle it is shown. Config writes are
// always ready.
module quadratic_patch_point_evaluator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_mode,
   input  logic [qppe_pkg::POS_BITS-1:0] req_col,
   input  logic [qppe_pkg::POS_BITS-1:0] req_row,
   input  logic signed [31:0]            req_point_x,
   input  logic signed [31:0]            req_point_y,
   input  logic signed [31:0]            req_point_z,
   input  logic signed [31:0]            req_point_u,
   input  logic signed [31:0]            req_point_v,
   input  logic [qppe_pkg::QUERY_BITS-1:0] req_query_x,
   input  logic [qppe_pkg::QUERY_BITS-1:0] req_query_y,
   output logic                          rsp_valid,
   output logic signed [31:0]            rsp_out_x,
   output logic signed [31:0]            rsp_out_y,
   output logic signed [31:0]            rsp_out_z,
   output logic signed [31:0]            rsp_out_u,
   output logic signed [31:0]            rsp_out_v,
   output logic                          rsp_corner_copy,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [qppe_pkg::CFG_BITS-1:0] csr_data
);

`include "assert_macros.svh"

   localparam int PW = qppe_pkg::NUM_CH * qppe_pkg::WORD_BITS;
   localparam logic [qppe_pkg::TAP_BITS-1:0] LAST_TAP =
      qppe_pkg::TAP_BITS'(qppe_pkg::NUM_TAPS-1);

   qppe_pkg::state_type state_ff, state_in;
   logic busy_ff, busy_in;
   logic [qppe_pkg::CFG_BITS-1:0] cols_ff, rows_ff;
   qppe_pkg::cen_type  cx_ff, cy_ff;
   qppe_pkg::frac_type tx_ff, ty_ff;
   logic [qppe_pkg::TAP_BITS-1:0] rd_col_ff, rd_col_in, rd_row_ff, rd_row_in;
   logic [qppe_pkg::TAP_BITS-1:0] dv_col_ff, dv_row_ff;
   logic dv_ff, dv_corner_ff;
   qppe_pkg::taps_type pts_ff, rowres_ff;
   logic rsp_valid_ff, rsp_corner_ff;
   qppe_pkg::point_type rsp_data_ff;

   qppe_pkg::side_type ncol, nrow;
   logic accept, wr_en, rd_en;
   logic [qppe_pkg::ADDR_BITS-1:0] wr_addr, rd_addr;
   logic [PW-1:0] wr_data, rd_data;
   qppe_pkg::point_type rd_point;
   qppe_pkg::cen_type   cx_q, cy_q;
   logic edge_x, edge_y;
   logic signed [qppe_pkg::IDX_BITS-1:0] idx_c, idx_r;

   qppe_pkg::red_tag_type red_tag_in, red_tag_out;
   qppe_pkg::taps_type    red_taps;
   qppe_pkg::frac_type    red_t;
   qppe_pkg::point_type   red_res;
   logic fire_row, fire_last, done_full, done_corner;

   assign ncol = qppe_pkg::eff_side(cols_ff);
   assign nrow = qppe_pkg::eff_side(rows_ff);
   assign accept = start && !busy_ff;
   assign csr_ready = 1'b1;

   // centre = round(q), fraction truncated
   assign cx_q = qppe_pkg::cen_type'((req_query_x
                 + (qppe_pkg::QUERY_BITS+1)'(1 << (qppe_pkg::FRAC_BITS-1)))
                 >> qppe_pkg::FRAC_BITS);
   assign cy_q = qppe_pkg::cen_type'((req_query_y
                 + (qppe_pkg::QUERY_BITS+1)'(1 << (qppe_pkg::FRAC_BITS-1)))
                 >> qppe_pkg::FRAC_BITS);
   assign edge_x = (cx_q == '0) || ((qppe_pkg::IDX_BITS)'(cx_q)
                   >= (qppe_pkg::IDX_BITS)'(ncol) - qppe_pkg::IDX_BITS'(1));
   assign edge_y = (cy_q == '0) || ((qppe_pkg::IDX_BITS)'(cy_q)
                   >= (qppe_pkg::IDX_BITS)'(nrow) - qppe_pkg::IDX_BITS'(1));

   // write path: a write request goes straight into the memory
   assign wr_en   = accept && !req_mode;
   assign wr_addr = {req_row, req_col};
   assign wr_data = {req_point_v, req_point_u, req_point_z, req_point_y, req_point_x};

   // read address: neighbourhood tap, or the centre itself for a corner copy
   always_comb begin
      if (state_ff == qppe_pkg::ST_CORNER) begin
         idx_c = $signed(qppe_pkg::IDX_BITS'(cx_ff));
         idx_r = $signed(qppe_pkg::IDX_BITS'(cy_ff));
      end else begin
         idx_c = $signed(qppe_pkg::IDX_BITS'(cx_ff)) + $signed(qppe_pkg::IDX_BITS'(rd_col_ff))
                 - qppe_pkg::IDX_BITS'(2);
         idx_r = $signed(qppe_pkg::IDX_BITS'(cy_ff)) + $signed(qppe_pkg::IDX_BITS'(rd_row_ff))
                 - qppe_pkg::IDX_BITS'(2);
      end
   end
   assign rd_addr = {qppe_pkg::clamp_idx(idx_r, nrow), qppe_pkg::clamp_idx(idx_c, ncol)};

   qppe_point_ram #(.WIDTH(PW), .DEPTH(qppe_pkg::DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );
   assign rd_point = qppe_pkg::point_type'(rd_data);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      busy_in   = busy_ff;
      rd_en     = 1'b0;
      rd_col_in = rd_col_ff;
      rd_row_in = rd_row_ff;
      case (state_ff)
         qppe_pkg::ST_IDLE: begin
            if (accept && req_mode) begin
               busy_in   = 1'b1;
               rd_col_in = '0;
               rd_row_in = '0;
               state_in  = (edge_x && edge_y) ? qppe_pkg::ST_CORNER : qppe_pkg::ST_READ;
            end
         end
         qppe_pkg::ST_READ: begin
            rd_en = 1'b1;
            if (rd_col_ff == LAST_TAP) begin
               rd_col_in = '0;
               rd_row_in = rd_row_ff + 1'b1;
               if (rd_row_ff == LAST_TAP) begin
                  state_in = qppe_pkg::ST_WAIT;
               end
            end else begin
               rd_col_in = rd_col_ff + 1'b1;
            end
         end
         qppe_pkg::ST_CORNER: begin
            rd_en    = 1'b1;
            state_in = qppe_pkg::ST_WAIT;
         end
         qppe_pkg::ST_WAIT: begin
            if (done_full || done_corner) begin
               busy_in  = 1'b0;
               state_in = qppe_pkg::ST_IDLE;
            end
         end
         default: state_in = qppe_pkg::ST_IDLE;
      endcase
   end

   // reduction feed: a row once its fifth tap lands, the column once row four is done
   assign fire_row    = dv_ff && !dv_corner_ff && (dv_col_ff == LAST_TAP);
   assign fire_last   = red_tag_out.valid && !red_tag_out.last_pass
                        && (red_tag_out.row == LAST_TAP);
   assign done_full   = red_tag_out.valid && red_tag_out.last_pass;
   assign done_corner = dv_ff && dv_corner_ff;

   always_comb begin
      red_tag_in = '0;
      red_taps   = '0;
      red_t      = tx_ff;
      if (fire_row) begin
         red_tag_in.valid = 1'b1;
         red_tag_in.row   = dv_row_ff;
         red_taps         = pts_ff;
         red_taps[qppe_pkg::NUM_TAPS-1] = rd_point;
      end else if (fire_last) begin
         red_tag_in.valid     = 1'b1;
         red_tag_in.last_pass = 1'b1;
         red_taps             = rowres_ff;
         red_taps[qppe_pkg::NUM_TAPS-1] = red_res;
         red_t                = ty_ff;
      end
   end

   qppe_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (red_tag_in),
      .taps    (red_taps),
      .t_in    (red_t),
      .tag_out (red_tag_out),
      .result  (red_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qppe_pkg::ST_IDLE;
         busy_ff      <= 1'b0;
         cols_ff      <= qppe_pkg::CFG_BITS'(3);
         rows_ff      <= qppe_pkg::CFG_BITS'(3);
         dv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_col_ff    <= '0;
         rd_row_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rd_col_ff    <= rd_col_in;
         rd_row_ff    <= rd_row_in;
         dv_ff        <= rd_en;
         rsp_valid_ff <= done_full || done_corner;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               qppe_pkg::CSR_GRID_COLS: cols_ff <= csr_data;
               qppe_pkg::CSR_GRID_ROWS: rows_ff <= csr_data;
               default: ;
            endcase
         end
      end
      if (accept && req_mode) begin
         cx_ff <= cx_q;
         cy_ff <= cy_q;
         tx_ff <= req_query_x[qppe_pkg::FRAC_BITS-1:0];
         ty_ff <= req_query_y[qppe_pkg::FRAC_BITS-1:0];
      end
      dv_col_ff    <= rd_col_ff;
      dv_row_ff    <= rd_row_ff;
      dv_corner_ff <= (state_ff == qppe_pkg::ST_CORNER);
      if (dv_ff && !dv_corner_ff) begin
         pts_ff[dv_col_ff] <= rd_point;
      end
      if (red_tag_out.valid && !red_tag_out.last_pass) begin
         rowres_ff[red_tag_out.row] <= red_res;
      end
      if (done_full) begin
         rsp_data_ff   <= red_res;
         rsp_corner_ff <= 1'b0;
      end else if (done_corner) begin
         rsp_data_ff   <= rd_point;
         rsp_corner_ff <= 1'b1;
      end
   end

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = rsp_data_ff[0];
   assign rsp_out_y       = rsp_data_ff[1];
   assign rsp_out_z       = rsp_data_ff[2];
   assign rsp_out_u       = rsp_data_ff[3];
   assign rsp_out_v       = rsp_data_ff[4];
   assign rsp_corner_copy = rsp_corner_ff;

   // strobe only once the request has retired
   `QPPE_NEVER(a_rsp_while_busy, clock, reset, rsp_valid_ff && busy_ff)
   // one strobe per evaluation, never two in a row
   `QPPE_ASSERT(a_rsp_single, clock, reset, rsp_valid_ff |=> !rsp_valid_ff)
   // column pass finishes only while the sequencer waits for it
   `QPPE_ASSERT(a_last_in_wait, clock, reset, done_full |-> state_ff == qppe_pkg::ST_WAIT)
   // memory reads happen only for an evaluation in flight
   `QPPE_ASSERT(a_read_busy, clock, reset, rd_en |-> busy_ff)

endmodule
